/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the decoder RTL.
// Expects clk and rst in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define DLE_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("decoder assertion failed");

// condition must never hold
`define DLE_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("decoder assertion failed");

`endif

/* hw/rtl/dle_pkg.sv */
// Package for the location expression decoder: phase enum, opcode ranges,
// result codes and the item structs. No dependencies.
package dle_pkg;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LEN  = 2'd1,
    PH_OPC  = 2'd2,
    PH_OFS  = 2'd3
  } phase_t;

  localparam logic [7:0] OPC_LIT_LO  = 8'h30;
  localparam logic [7:0] OPC_LIT_HI  = 8'h4f;
  localparam logic [7:0] OPC_REG_LO  = 8'h50;
  localparam logic [7:0] OPC_REG_HI  = 8'h6f;
  localparam logic [7:0] OPC_BREG_LO = 8'h70;
  localparam logic [7:0] OPC_BREG_HI = 8'h8f;

  localparam logic [5:0] SHIFT_SAT = 6'd35;
  localparam logic [5:0] SHIFT_STEP = 6'd7;
  localparam logic [5:0] WORD_BITS = 6'd32;

  localparam logic [1:0] KIND_LIT  = 2'd0;
  localparam logic [1:0] KIND_REG  = 2'd1;
  localparam logic [1:0] KIND_BREG = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_REG = 2'd1;
  localparam logic [1:0] ST_BAD_OPC = 2'd2;

  localparam logic [4:0] HIGHEST_REG_RESET = 5'd15;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_req;
  } byte_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [4:0]         reg_index;
    logic signed [31:0] offset;
    logic [1:0]         status;
    logic               length_warning;
  } result_t;

endpackage

/* hw/rtl/dle_if.sv */
// Handshake channels of the decoder: byte input, result output, config write.
// Depends on nothing.
interface dle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_req;
  modport source (output valid, output data_byte, output start_req, input ready);
  modport sink   (input valid, input data_byte, input start_req, output ready);
endinterface

interface dle_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [4:0]         reg_index;
  logic signed [31:0] offset;
  logic [1:0]         status;
  logic               length_warning;
  modport source (output valid, output kind, output reg_index, output offset,
                  output status, output length_warning, input ready);
  modport sink   (input valid, input kind, input reg_index, input offset,
                  input status, input length_warning, output ready);
endinterface

interface dle_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/dle_in_stage.sv */
// Input register of the decoder: holds one accepted byte item.
// Depends on dle_pkg and dle_in_if.
module dle_in_stage (
  input  logic                clk,
  input  logic                rst,
  dle_in_if.sink              chan,
  input  logic                advance,
  output logic                item_valid,
  output dle_pkg::byte_item_t item
);

  logic                valid_q;
  dle_pkg::byte_item_t item_q;

  assign chan.ready = !valid_q || advance;
  assign item_valid = valid_q;
  assign item       = item_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (chan.ready) begin
      valid_q <= chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chan.valid && chan.ready) begin
      item_q.data_byte <= chan.data_byte;
      item_q.start_req <= chan.start_req;
    end
  end

endmodule

/* hw/rtl/dle_parser.sv */
// Expression parser: phase state, LEB128 accumulation and opcode decode.
// Depends on dle_pkg.
module dle_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  dle_pkg::byte_item_t item,
  input  logic [4:0]          highest_register,
  output logic                emit,
  output dle_pkg::result_t    result
);

  dle_pkg::phase_t phase, phase_next, phase_eff;
  logic [5:0]  shift_count, shift_count_next, sc_eff, sc_gather, sc_sum;
  logic [31:0] accumulator, accumulator_next, acc_eff, acc_gather, ofs_final;
  logic        length_is_one, length_is_one_next, lio_eff;
  logic [4:0]  pending_register, pending_register_next, preg_eff;
  logic        pending_error, pending_error_next, perr_eff;

  logic [7:0]  b;
  logic        is_lit, is_reg, is_breg;
  logic [4:0]  lit_n, reg_n, breg_n;

  assign b = item.data_byte;

  // a start byte clears everything and is the first length byte
  always_comb begin
    phase_eff = item.start_req ? dle_pkg::PH_LEN : phase;
    sc_eff    = item.start_req ? 6'd0 : shift_count;
    acc_eff   = item.start_req ? 32'd0 : accumulator;
    lio_eff   = item.start_req ? 1'b0 : length_is_one;
    preg_eff  = item.start_req ? 5'd0 : pending_register;
    perr_eff  = item.start_req ? 1'b0 : pending_error;
  end

  // one LEB128 byte: or in 7 bits below bit 32, saturating shift count
  always_comb begin
    sc_sum     = sc_eff + dle_pkg::SHIFT_STEP;
    sc_gather  = (sc_sum > dle_pkg::SHIFT_SAT) ? dle_pkg::SHIFT_SAT : sc_sum;
    acc_gather = acc_eff;
    if (sc_eff < dle_pkg::WORD_BITS) begin
      acc_gather = acc_eff | ({25'd0, b[6:0]} << sc_eff[4:0]);
    end
    ofs_final = acc_gather;
    if (sc_gather < dle_pkg::WORD_BITS && b[6]) begin
      ofs_final = acc_gather | (32'hffff_ffff << sc_gather[4:0]);
    end
  end

  always_comb begin
    is_lit  = (b >= dle_pkg::OPC_LIT_LO)  && (b <= dle_pkg::OPC_LIT_HI);
    is_reg  = (b >= dle_pkg::OPC_REG_LO)  && (b <= dle_pkg::OPC_REG_HI);
    is_breg = (b >= dle_pkg::OPC_BREG_LO) && (b <= dle_pkg::OPC_BREG_HI);
    lit_n   = 5'(b - dle_pkg::OPC_LIT_LO);
    reg_n   = 5'(b - dle_pkg::OPC_REG_LO);
    breg_n  = 5'(b - dle_pkg::OPC_BREG_LO);
  end

  // next state
  always_comb begin
    phase_next            = phase_eff;
    shift_count_next      = sc_eff;
    accumulator_next      = acc_eff;
    length_is_one_next    = lio_eff;
    pending_register_next = preg_eff;
    pending_error_next    = perr_eff;
    case (phase_eff)
      dle_pkg::PH_LEN: begin
        shift_count_next = sc_gather;
        accumulator_next = acc_gather;
        if (!b[7]) begin
          length_is_one_next = (acc_gather == 32'd1);
          phase_next         = dle_pkg::PH_OPC;
        end
      end
      dle_pkg::PH_OPC: begin
        phase_next = dle_pkg::PH_IDLE;
        if (!is_reg && !is_lit && is_breg) begin
          pending_register_next = breg_n;
          pending_error_next    = breg_n > highest_register;
          shift_count_next      = 6'd0;
          accumulator_next      = 32'd0;
          phase_next            = dle_pkg::PH_OFS;
        end
      end
      dle_pkg::PH_OFS: begin
        shift_count_next = sc_gather;
        accumulator_next = acc_gather;
        if (!b[7]) begin
          accumulator_next = ofs_final;
          phase_next       = dle_pkg::PH_IDLE;
        end
      end
      default: begin
        phase_next = dle_pkg::PH_IDLE;
      end
    endcase
  end

  // result
  always_comb begin
    emit                  = 1'b0;
    result.kind           = dle_pkg::KIND_LIT;
    result.reg_index      = 5'd0;
    result.offset         = 32'sd0;
    result.status         = dle_pkg::ST_OK;
    result.length_warning = 1'b0;
    case (phase_eff)
      dle_pkg::PH_OPC: begin
        if (is_reg) begin
          emit                  = 1'b1;
          result.kind           = dle_pkg::KIND_REG;
          result.length_warning = !lio_eff;
          if (reg_n <= highest_register) begin
            result.reg_index = reg_n;
          end else begin
            result.status = dle_pkg::ST_BAD_REG;
          end
        end else if (is_lit) begin
          emit                  = 1'b1;
          result.offset         = signed'({27'd0, lit_n});
          result.length_warning = !lio_eff;
        end else if (!is_breg) begin
          emit          = 1'b1;
          result.status = dle_pkg::ST_BAD_OPC;
        end
      end
      dle_pkg::PH_OFS: begin
        if (!b[7]) begin
          emit        = 1'b1;
          result.kind = dle_pkg::KIND_BREG;
          if (perr_eff) begin
            result.status = dle_pkg::ST_BAD_REG;
          end else begin
            result.reg_index = preg_eff;
            result.offset    = signed'(ofs_final);
          end
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= dle_pkg::PH_IDLE;
      shift_count      <= 6'd0;
      accumulator      <= 32'd0;
      length_is_one    <= 1'b0;
      pending_register <= 5'd0;
      pending_error    <= 1'b0;
    end else if (advance) begin
      phase            <= phase_next;
      shift_count      <= shift_count_next;
      accumulator      <= accumulator_next;
      length_is_one    <= length_is_one_next;
      pending_register <= pending_register_next;
      pending_error    <= pending_error_next;
    end
  end

endmodule

/* hw/rtl/dle_out_reg.sv */
// Result register: holds one result item until the sink takes it.
// Depends on dle_pkg and dle_out_if.
module dle_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  dle_pkg::result_t result,
  output logic             free,
  dle_out_if.source        chan
);

  logic             valid_q;
  dle_pkg::result_t result_q;

  assign free                = !valid_q || chan.ready;
  assign chan.valid          = valid_q;
  assign chan.kind           = result_q.kind;
  assign chan.reg_index      = result_q.reg_index;
  assign chan.offset         = result_q.offset;
  assign chan.status         = result_q.status;
  assign chan.length_warning = result_q.length_warning;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (free) begin
      valid_q <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      result_q <= result;
    end
  end

endmodule

/* hw/rtl/dwarf_location_expr_decoder_top.sv */
// Top level of the location expression decoder.
// Depends on dle_pkg, dle_if, dle_in_stage, dle_parser, dle_out_reg, assert_macros.svh.
//
// Decodes a DWARF location expression one byte per item: an unsigned LEB128
// length, then one opcode (lit0..31, reg0..31, or breg0..31 followed by a
// signed LEB128 offset). A byte with start_req set begins a new expression
// and drops any unfinished one. lit, reg and an unknown opcode give a
// result at the opcode byte, breg at the last offset byte; bytes after a
// result are ignored until the next start. The block takes one byte every
// clock while its output register can take a result: each byte goes to
// an input register, is parsed by one pass of shift/or and compare logic,
// and its result (if any) is loaded into the output register, which holds
// it until the sink takes it. A result held under a stalled sink blocks
// the parser, also for bytes that give no result. highest_register (reset 15)
// is written through cfg_chan, always ready, and should change only while
// no expression is in flight.
`include "assert_macros.svh"

module dwarf_location_expr_decoder_top (
  input  logic      clk,
  input  logic      rst,
  dle_in_if.sink    data_chan,
  dle_out_if.source result_chan,
  dle_cfg_if.sink   cfg_chan
);

  logic                item_valid;
  dle_pkg::byte_item_t item;
  logic                advance;   // parser consumes the held byte this cycle
  logic                out_free;  // result register can take a new item
  logic                emit;
  dle_pkg::result_t    result;
  logic [4:0]          highest_register;

  // config register, write port never stalls
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      highest_register <= dle_pkg::HIGHEST_REG_RESET;
    end else if (cfg_chan.valid) begin
      highest_register <= cfg_chan.data;
    end
  end

  // a byte moves on only if its possible result has somewhere to go
  assign advance = item_valid && out_free;

  dle_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .chan       (data_chan),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  dle_parser u_parser (
    .clk              (clk),
    .rst              (rst),
    .advance          (advance),
    .item             (item),
    .highest_register (highest_register),
    .emit             (emit),
    .result           (result)
  );

  dle_out_reg u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (advance && emit),
    .result (result),
    .free   (out_free),
    .chan   (result_chan)
  );

  // checks
  `DLE_ASSERT_NEVER(a_kind_code, result_chan.valid && (result_chan.kind > dle_pkg::KIND_BREG))
  `DLE_ASSERT_IMPL(a_bad_opc_clean,
    result_chan.valid && (result_chan.status == dle_pkg::ST_BAD_OPC),
    (result_chan.reg_index == 5'd0) && (result_chan.offset == 32'sd0) &&
    !result_chan.length_warning && (result_chan.kind == dle_pkg::KIND_LIT))
  `DLE_ASSERT_IMPL(a_bad_reg_clean,
    result_chan.valid && (result_chan.status == dle_pkg::ST_BAD_REG),
    (result_chan.reg_index == 5'd0) && (result_chan.offset == 32'sd0))
  `DLE_ASSERT_IMPL(a_breg_no_warn,
    result_chan.valid && (result_chan.kind == dle_pkg::KIND_BREG),
    !result_chan.length_warning)

endmodule

/* tb/sv/dwarf_location_expr_decoder_top_test.sv */
// Self-checking bench for the DWARF location expression decoder: a byte
// driver, a result monitor and a bit-exact decode predictor.
// Depends on dle_pkg, dle_if and dwarf_location_expr_decoder_top.
module dwarf_location_expr_decoder_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Watchdog: cycles with no item accepted on any channel. The longest
  // legal quiet stretch is the forced receiver hold (HOLD_CYCLES) plus the
  // pipeline registers, so this is several times the worst case.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  // The result of the last byte passes the input and output registers; leave
  // margin before a register write or the end of the run.
  localparam int DRAIN_CYCLES   = 8;
  localparam int PHASE_BYTES    = 280;
  localparam int MAX_REPORTS    = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #1 clk = ~clk;

  dle_in_if  data_chan();
  dle_out_if result_chan();
  dle_cfg_if cfg_chan();

  dwarf_location_expr_decoder_top u_dut (
    .clk         (clk),
    .rst         (rst),
    .data_chan   (data_chan),
    .result_chan (result_chan),
    .cfg_chan    (cfg_chan)
  );

  // ---------------------------------------------------------------------
  // Decode predictor state (own copy of the block's state and register)
  // ---------------------------------------------------------------------
  dle_pkg::phase_t pr_phase    = dle_pkg::PH_IDLE;
  logic [5:0]      pr_shift    = '0;
  logic [31:0]     pr_acc      = '0;
  logic            pr_len_one  = 1'b0;
  logic [4:0]      pr_pend_reg = '0;
  logic            pr_pend_err = 1'b0;
  logic [4:0]      cfg_highest = dle_pkg::HIGHEST_REG_RESET;

  dle_pkg::byte_item_t byte_queue[$];       // bytes waiting for the driver
  dle_pkg::result_t    decoded_results[$];  // predicted results, oldest first

  // Idling knobs, percent of cycles; changed only between phases.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  logic hold_request = 1'b0;
  int   hold_left;

  int errors       = 0;
  int mismatches   = 0;
  int bytes_sent   = 0;
  int results_seen = 0;
  int kind_count[3];
  int bad_reg_seen = 0;
  int bad_opc_seen = 0;
  int warn_seen    = 0;
  int cfg_writes   = 0;
  int idle_cycles;

  // One LEB128 group: bits at or past bit 32 are dropped, shift saturates.
  function automatic void leb_gather(input logic [7:0] b);
    logic [63:0] wide;
    wide = {57'd0, b[6:0]} << pr_shift;
    if (pr_shift < dle_pkg::WORD_BITS) pr_acc |= wide[31:0];
    pr_shift = (pr_shift + dle_pkg::SHIFT_STEP > dle_pkg::SHIFT_SAT) ?
               dle_pkg::SHIFT_SAT : pr_shift + dle_pkg::SHIFT_STEP;
  endfunction

  // Advances the predictor by one byte; returns 1 when the byte yields a result.
  function automatic bit decode_byte(input logic [7:0] b, input logic st,
                                     output dle_pkg::result_t r);
    logic [4:0] n;
    logic       warn;
    r = '0;
    if (st) begin
      pr_phase    = dle_pkg::PH_LEN;
      pr_shift    = '0;
      pr_acc      = '0;
      pr_len_one  = 1'b0;
      pr_pend_reg = '0;
      pr_pend_err = 1'b0;
    end
    case (pr_phase)
      dle_pkg::PH_LEN: begin
        leb_gather(b);
        if (!b[7]) begin
          pr_len_one = (pr_acc == 32'd1);
          pr_phase   = dle_pkg::PH_OPC;
        end
        return 1'b0;
      end
      dle_pkg::PH_OPC: begin
        warn     = !pr_len_one;
        pr_phase = dle_pkg::PH_IDLE;
        if (b >= dle_pkg::OPC_REG_LO && b <= dle_pkg::OPC_REG_HI) begin
          n = 5'(b - dle_pkg::OPC_REG_LO);
          r.kind = dle_pkg::KIND_REG;
          r.length_warning = warn;
          if (n <= cfg_highest) r.reg_index = n;
          else r.status = dle_pkg::ST_BAD_REG;
          return 1'b1;
        end
        if (b >= dle_pkg::OPC_LIT_LO && b <= dle_pkg::OPC_LIT_HI) begin
          r.kind = dle_pkg::KIND_LIT;
          r.offset = 32'(b - dle_pkg::OPC_LIT_LO);
          r.length_warning = warn;
          return 1'b1;
        end
        if (b >= dle_pkg::OPC_BREG_LO && b <= dle_pkg::OPC_BREG_HI) begin
          n = 5'(b - dle_pkg::OPC_BREG_LO);
          pr_pend_reg = n;
          pr_pend_err = (n > cfg_highest);
          pr_shift    = '0;
          pr_acc      = '0;
          pr_phase    = dle_pkg::PH_OFS;
          return 1'b0;
        end
        r.kind   = dle_pkg::KIND_LIT;
        r.status = dle_pkg::ST_BAD_OPC;
        return 1'b1;
      end
      dle_pkg::PH_OFS: begin
        leb_gather(b);
        if (b[7]) return 1'b0;
        // sign-extend only when fewer than 32 bits came in
        if (pr_shift < dle_pkg::WORD_BITS && b[6]) pr_acc |= 32'hffff_ffff << pr_shift;
        pr_phase = dle_pkg::PH_IDLE;
        r.kind   = dle_pkg::KIND_BREG;
        if (pr_pend_err) begin
          r.status = dle_pkg::ST_BAD_REG;
        end else begin
          r.reg_index = pr_pend_reg;
          r.offset    = pr_acc;
        end
        return 1'b1;
      end
      default: begin
        // idle, no start: byte is dropped
        pr_phase = dle_pkg::PH_IDLE;
        return 1'b0;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Driver: offers bytes from byte_queue, predicts on each accepted item.
  // valid stays up until the item is taken.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : byte_driver
    dle_pkg::byte_item_t nxt;
    dle_pkg::result_t    r;
    if (rst) begin
      data_chan.valid <= 1'b0;
    end else begin
      if (data_chan.valid && data_chan.ready) begin
        bytes_sent++;
        if (decode_byte(data_chan.data_byte, data_chan.start_req, r))
          decoded_results.push_back(r);
      end
      if (!data_chan.valid || data_chan.ready) begin
        if (byte_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = byte_queue.pop_front();
          data_chan.valid     <= 1'b1;
          data_chan.data_byte <= nxt.data_byte;
          data_chan.start_req <= nxt.start_req;
        end else begin
          data_chan.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here so the monitor only looks at it.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_request && hold_left == 0) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: random ready, compares each accepted result with the oldest
  // prediction field by field.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    dle_pkg::result_t want;
    logic             bad;
    if (rst) begin
      result_chan.ready <= 1'b0;
    end else begin
      if (result_chan.valid && result_chan.ready) begin
        results_seen++;
        if (decoded_results.size() == 0) begin
          errors++;
          mismatches++;
          // fields in order kind/reg/offset/status/warning
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result with nothing predicted: %0d/%0d/%0d/%0d/%0d",
                     $realtime, result_chan.kind, result_chan.reg_index,
                     result_chan.offset, result_chan.status, result_chan.length_warning);
        end else begin
          want = decoded_results.pop_front();
          if (want.kind <= dle_pkg::KIND_BREG) kind_count[want.kind]++;
          if (want.status == dle_pkg::ST_BAD_REG) bad_reg_seen++;
          if (want.status == dle_pkg::ST_BAD_OPC) bad_opc_seen++;
          if (want.length_warning) warn_seen++;
          bad = (result_chan.kind !== want.kind) ||
                (result_chan.reg_index !== want.reg_index) ||
                (result_chan.offset !== want.offset) ||
                (result_chan.status !== want.status) ||
                (result_chan.length_warning !== want.length_warning);
          if (bad) begin
            errors++;
            mismatches++;
            // fields in order kind/reg/offset/status/warning
            if (mismatches <= MAX_REPORTS)
              $display("%0t: exp %0d/%0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d/%0d",
                       $realtime, want.kind, want.reg_index, want.offset, want.status,
                       want.length_warning, result_chan.kind, result_chan.reg_index,
                       result_chan.offset, result_chan.status, result_chan.length_warning);
          end
        end
      end
      result_chan.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog: any accepted item on any channel restarts the count.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((data_chan.valid && data_chan.ready) ||
                 (result_chan.valid && result_chan.ready) ||
                 (cfg_chan.valid && cfg_chan.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no item accepted for %0d cycles", $realtime, WATCHDOG_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  function automatic void push_byte(input logic [7:0] b, input logic st);
    byte_queue.push_back({b, st});
  endfunction

  // One random expression, mostly well formed; some are cut short, some
  // carry trailing junk or a stray byte. Returns the bytes that count.
  function automatic int add_expression();
    dle_pkg::byte_item_t seq[$];
    int unsigned         sel;
    int                  n;
    int                  cut;
    logic [7:0]          b;
    // length: mostly 1, sometimes another value, redundant 1, or multi-byte
    sel = $urandom_range(0, 9);
    if (sel < 7) begin
      seq.push_back({8'h01, 1'b1});
    end else if (sel == 7) begin
      b = 8'($urandom);
      b[7] = 1'b0;
      seq.push_back({b, 1'b1});
    end else if (sel == 8) begin
      seq.push_back({8'h81, 1'b1});
      seq.push_back({8'h00, 1'b0});
    end else begin
      n = $urandom_range(2, 6);
      for (int i = 0; i < n; i++) begin
        b = 8'($urandom);
        b[7] = (i != n - 1);
        seq.push_back({b, i == 0});
      end
    end
    // opcode
    sel = $urandom_range(0, 99);
    if (sel < 30) b = 8'(dle_pkg::OPC_LIT_LO + $urandom_range(0, 31));
    else if (sel < 55) b = 8'(dle_pkg::OPC_REG_LO + $urandom_range(0, 31));
    else if (sel < 90) b = 8'(dle_pkg::OPC_BREG_LO + $urandom_range(0, 31));
    else b = 8'($urandom);
    seq.push_back({b, 1'b0});
    // signed offset: mostly short, a few past 32 bits
    if (b >= dle_pkg::OPC_BREG_LO && b <= dle_pkg::OPC_BREG_HI) begin
      sel = $urandom_range(0, 9);
      n = (sel < 4) ? 1 : (sel < 7) ? 2 : (sel < 8) ? 3 : $urandom_range(4, 6);
      for (int i = 0; i < n; i++) begin
        b = 8'($urandom);
        b[7] = (i != n - 1);
        seq.push_back({b, 1'b0});
      end
    end
    n = seq.size();
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      // broken: the next start aborts it
      cut = $urandom_range(1, n - 1);
      n = cut;
      while (seq.size() > cut) void'(seq.pop_back());
    end
    foreach (seq[i]) byte_queue.push_back(seq[i]);
    if (sel >= 8 && sel < 14) begin
      // trailing bytes after the result are ignored
      repeat ($urandom_range(1, 3)) push_byte(8'($urandom), 1'b0);
    end else if (sel >= 14 && sel < 17) begin
      push_byte(8'($urandom), 1'($urandom_range(0, 1)));
    end
    return n;
  endfunction

  // Sampled at the falling edge so posedge updates have settled.
  task automatic wait_idle();
    while (byte_queue.size() != 0 || decoded_results.size() != 0 || data_chan.valid)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_highest(input logic [4:0] v);
    wait_idle();
    @(posedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.data  <= v;
    do @(posedge clk); while (!cfg_chan.ready);
    cfg_highest = v;
    cfg_writes++;
    cfg_chan.valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [4:0] highest, input int unsigned send_pct,
                           input int unsigned recv_pct, input bit with_hold);
    int added;
    write_highest(highest);
    @(negedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    added = 0;
    while (added < PHASE_BYTES) added += add_expression();
    if (with_hold) begin
      // receiver stops while the sender keeps offering: block backs up
      hold_request = 1'b1;
      @(negedge clk);
      hold_request = 1'b0;
    end
  endtask

  initial begin
    data_chan.valid     = 1'b0;
    data_chan.data_byte = '0;
    data_chan.start_req = 1'b0;
    result_chan.ready   = 1'b0;
    cfg_chan.valid      = 1'b0;
    cfg_chan.data       = '0;
    kind_count          = '{default: 0};

    // Directed expressions with highest_register at its reset value.
    push_byte(8'h01, 1'b1); push_byte(8'h30, 1'b0);   // lit0
    push_byte(8'h00, 1'b1); push_byte(8'h4f, 1'b0);   // lit31, length 0 warns
    push_byte(8'h01, 1'b1); push_byte(8'h5f, 1'b0);   // reg15, top of range
    push_byte(8'h02, 1'b1); push_byte(8'h60, 1'b0);   // reg16 out of range, warns
    push_byte(8'h01, 1'b1); push_byte(8'h70, 1'b0);   // breg0, offset -64
    push_byte(8'h40, 1'b0);
    push_byte(8'h01, 1'b1); push_byte(8'h8f, 1'b0);   // breg31 out of range,
    push_byte(8'hff, 1'b0); push_byte(8'h7f, 1'b0);   // offset still consumed
    push_byte(8'h01, 1'b1); push_byte(8'hff, 1'b0);   // unknown opcode
    push_byte(8'h55, 1'b0);                           // idle, no start: dropped
    push_byte(8'h81, 1'b1);                           // aborted mid length
    push_byte(8'h01, 1'b1); push_byte(8'h52, 1'b0);   // reg2
    push_byte(8'h81, 1'b1); push_byte(8'h80, 1'b0);   // length 2^32+1 truncates
    push_byte(8'h80, 1'b0); push_byte(8'h80, 1'b0);   // to 1: no warning
    push_byte(8'h10, 1'b0); push_byte(8'h3a, 1'b0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Random phases: register extremes and idling patterns.
    run_phase(5'd31, 0, 0, 1'b1);
    run_phase(5'd0, 80, 0, 1'b0);
    run_phase(5'd7, 0, 80, 1'b0);
    run_phase(5'($urandom_range(1, 30)), 6, 6, 1'b0);
    run_phase(5'd15, 0, 0, 1'b0);

    wait_idle();
    $display("Covered %0d bytes, %0d results (lit %0d, reg %0d, breg %0d), %0d writes",
             bytes_sent, results_seen, kind_count[dle_pkg::KIND_LIT],
             kind_count[dle_pkg::KIND_REG], kind_count[dle_pkg::KIND_BREG], cfg_writes);
    $display("Bad register %0d, unknown opcode %0d, length warnings %0d, mismatches %0d",
             bad_reg_seen, bad_opc_seen, warn_seen, mismatches);
    if (errors == 0 && decoded_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
